### hw/rtl/hfdm_pkg.sv
// Types and constants shared by the hysteresis frequency and duty meter.
package hfdm_pkg;

   localparam int TIME_W = 48;
   localparam int PERIOD_W = 32;
   localparam int FREQ_W = 30;
   localparam int DUTY_W = 14;
   localparam int COUNT_W = 32;
   localparam int PROD_W = PERIOD_W + DUTY_W;

   localparam logic [FREQ_W-1:0] MHZ_NUMERATOR = FREQ_W'(1000000000);
   localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(10000);

   localparam logic [1:0] EDGE_NONE = 2'd0;
   localparam logic [1:0] EDGE_RISE = 2'd1;
   localparam logic [1:0] EDGE_FALL = 2'd2;

   localparam logic [1:0] REG_TRIGGER = 2'd0;
   localparam logic [1:0] REG_BAND = 2'd1;
   localparam logic [1:0] REG_ENABLE = 2'd2;

   localparam logic DIV_FREQ = 1'b0;
   localparam logic DIV_DUTY = 1'b1;

   typedef struct packed {
      logic                level_high;
      logic                rise_seen;
      logic [TIME_W-1:0]   last_rise_time;
      logic [PERIOD_W-1:0] period_store;
      logic [FREQ_W-1:0]   frequency_store;
      logic [PERIOD_W-1:0] pulse_store;
      logic [DUTY_W-1:0]   duty_store;
      logic [COUNT_W-1:0]  edge_counter;
   } chan_state_type;

   function automatic logic [PERIOD_W-1:0] sat32(input logic [TIME_W-1:0] v);
      logic [PERIOD_W-1:0] r;
      r = (v[TIME_W-1:PERIOD_W] != '0) ? '1 : v[PERIOD_W-1:0];
      return r;
   endfunction

endpackage

### hw/rtl/hysteresis_frequency_duty_meter.sv
// Top level of the hysteresis frequency and duty meter with its per-channel state memory.
//
// Samples arrive on the req_ channel, one beat per sample, each tagged with a channel
// index and a microsecond timestamp. Every sample yields exactly one beat on the rsp_
// channel carrying that channel's current period, frequency, pulse width, duty cycle
// and edge count. Thresholds and the channel enable mask are set over the csr_ port.
// The block handles one sample at a time. A sample that needs no division passes from
// evaluation to the final step, and the next sample is accepted once the block is back
// in idle. A rising edge with a known previous rise runs 30 steps of the shared
// restoring divider before the final step; a falling edge that needs a duty division
// runs a multiply, a setup step and 14 divider steps before it.
// A finished result sits in an output register, and the next sample is accepted
// while it waits; if the receiver stalls, the following sample waits in its final
// step until the output register frees up. Reset clears the control and configuration
// registers, the valid bit of every channel entry and the output valid bit, and
// req_ready stays low while reset is high; the memory needs no clearing pass. Writing
// channel_enable wipes the state of every disabled channel.
module hysteresis_frequency_duty_meter
   import hfdm_pkg::*;
#(
   parameter int NUM_CHANNELS = 4,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_channel_index,
   input  logic [SAMPLE_BITS-1:0] req_sample_value,
   input  logic [TIME_W-1:0]      req_time_us,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_out_channel,
   output logic                   rsp_channel_active,
   output logic [1:0]             rsp_edge_kind,
   output logic [PERIOD_W-1:0]    rsp_period_us,
   output logic [FREQ_W-1:0]      rsp_frequency_mhz,
   output logic [PERIOD_W-1:0]    rsp_pulse_width_us,
   output logic [DUTY_W-1:0]      rsp_duty_centipercent,
   output logic [COUNT_W-1:0]     rsp_edge_total,

   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [3:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   localparam int MEM_DEPTH = (NUM_CHANNELS < 4) ? NUM_CHANNELS : 4;
   localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int CMP_W = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 2;
   localparam int DCNT_W = $clog2(FREQ_W + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EVAL = 3'd1;
   localparam logic [2:0] S_MUL = 3'd2;
   localparam logic [2:0] S_DIV = 3'd3;
   localparam logic [2:0] S_FIN = 3'd4;

   // Configuration registers.
   logic signed [15:0] trig_ff;
   logic [13:0]        band_ff;
   logic [3:0]         enable_ff;
   logic               csr_wr;

   // Control.
   logic [2:0]         state_ff, state_in;
   logic               req_accept;
   logic               active_ff, active_in;
   logic [1:0]         edge_ff, edge_in;

   // Sample holding registers.
   logic [1:0]                    ch_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic [TIME_W-1:0]             time_ff;

   // State memory and entry valid bits.
   chan_state_type     chan_mem [MEM_DEPTH];
   chan_state_type     rd_data_ff;
   logic               rd_valid_ff;
   logic [MEM_DEPTH-1:0] valid_ff;
   logic [ADDR_W-1:0]  req_addr;
   logic [ADDR_W-1:0]  ch_addr;
   logic               mem_wr;

   // Working copy of the entry under update.
   chan_state_type     work_ff, work_in;
   logic [PERIOD_W-1:0] wid_ff, wid_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;

   // Shared restoring divider.
   logic [TIME_W-1:0]  div_rem_ff, div_rem_in;
   logic [FREQ_W-1:0]  div_num_ff, div_num_in;
   logic [TIME_W-1:0]  div_den_ff, div_den_in;
   logic [FREQ_W-1:0]  div_quo_ff, div_quo_in;
   logic [DCNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic               div_kind_ff, div_kind_in;
   logic [TIME_W:0]    div_trial;
   logic [TIME_W:0]    div_sub;
   logic               div_ge;
   logic [FREQ_W-1:0]  div_quo_next;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_load;
   logic [1:0]         rsp_ch_ff;
   logic               rsp_active_ff;
   logic [1:0]         rsp_edge_ff;
   chan_state_type     rsp_state_ff;

   // Evaluation temporaries.
   chan_state_type     cur;
   logic signed [CMP_W-1:0] s_ext, upper, lower;
   logic               now_high;
   logic               time_gt;
   logic               time_ge;
   logic [TIME_W-1:0]  time_diff;
   logic [TIME_W-1:0]  width_full;
   logic               req_active;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      case (csr_paddr[3:2])
         REG_TRIGGER: csr_prdata = {{16{trig_ff[15]}}, trig_ff};
         REG_BAND:    csr_prdata = {18'd0, band_ff};
         REG_ENABLE:  csr_prdata = {28'd0, enable_ff};
         default:     csr_prdata = '0;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign req_accept = req_valid & req_ready;
   assign req_addr = ADDR_W'(req_channel_index);
   assign ch_addr = ADDR_W'(ch_ff);
   assign req_active = (int'(req_channel_index) < MEM_DEPTH) && enable_ff[req_channel_index];

   assign rsp_load = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);
   assign mem_wr = rsp_load && active_ff;

   assign cur = rd_valid_ff ? rd_data_ff : '0;
   assign s_ext = CMP_W'(sample_ff);
   assign upper = CMP_W'(trig_ff) + CMP_W'(signed'({1'b0, band_ff}));
   assign lower = CMP_W'(trig_ff) - CMP_W'(signed'({1'b0, band_ff}));
   assign now_high = cur.level_high ? !(s_ext < lower) : (s_ext > upper);
   assign time_gt = time_ff > cur.last_rise_time;
   assign time_ge = time_ff >= cur.last_rise_time;
   assign time_diff = time_ff - cur.last_rise_time;
   assign width_full = time_ge ? time_diff : '0;

   assign div_trial = {div_rem_ff, div_num_ff[FREQ_W-1]};
   assign div_sub = div_trial - {1'b0, div_den_ff};
   assign div_ge = div_trial >= {1'b0, div_den_ff};
   assign div_quo_next = {div_quo_ff[FREQ_W-2:0], div_ge};

   always_comb begin
      state_in = state_ff;
      active_in = active_ff;
      edge_in = edge_ff;
      work_in = work_ff;
      wid_in = wid_ff;
      prod_in = prod_ff;
      div_rem_in = div_rem_ff;
      div_num_in = div_num_ff;
      div_den_in = div_den_ff;
      div_quo_in = div_quo_ff;
      div_cnt_in = div_cnt_ff;
      div_kind_in = div_kind_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               active_in = req_active;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            work_in = cur;
            work_in.level_high = now_high;
            edge_in = EDGE_NONE;
            state_in = S_FIN;
            if (!active_ff) begin
               work_in = '0;
            end else if (now_high && !cur.level_high) begin
               edge_in = EDGE_RISE;
               if (cur.rise_seen && time_gt) begin
                  work_in.period_store = sat32(time_diff);
                  div_rem_in = '0;
                  div_num_in = MHZ_NUMERATOR;
                  div_den_in = time_diff;
                  div_quo_in = '0;
                  div_cnt_in = DCNT_W'(FREQ_W);
                  div_kind_in = DIV_FREQ;
                  state_in = S_DIV;
               end
               work_in.last_rise_time = time_ff;
               work_in.rise_seen = 1'b1;
               work_in.edge_counter = cur.edge_counter + 1'b1;
            end else if (!now_high && cur.level_high) begin
               edge_in = EDGE_FALL;
               if (cur.rise_seen) begin
                  work_in.pulse_store = sat32(width_full);
                  if (cur.period_store != '0) begin
                     if (width_full >= {{(TIME_W-PERIOD_W){1'b0}}, cur.period_store}) begin
                        work_in.duty_store = DUTY_FULL;
                     end else begin
                        wid_in = width_full[PERIOD_W-1:0];
                        state_in = S_MUL;
                     end
                  end
               end
               work_in.edge_counter = cur.edge_counter + 1'b1;
            end
         end
         S_MUL: begin
            prod_in = PROD_W'(wid_ff) * PROD_W'(DUTY_FULL);
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_cnt_ff == '0) begin
               // Duty division: the quotient stays below 2^14, so the upper
               // product bits already form a remainder below the divisor.
               div_rem_in = TIME_W'(prod_ff[PROD_W-1:DUTY_W]);
               div_num_in = {prod_ff[DUTY_W-1:0], {(FREQ_W-DUTY_W){1'b0}}};
               div_den_in = TIME_W'(work_ff.period_store);
               div_quo_in = '0;
               div_cnt_in = DCNT_W'(DUTY_W);
               div_kind_in = DIV_DUTY;
            end else begin
               div_rem_in = div_ge ? div_sub[TIME_W-1:0] : div_trial[TIME_W-1:0];
               div_num_in = {div_num_ff[FREQ_W-2:0], 1'b0};
               div_quo_in = div_quo_next;
               div_cnt_in = div_cnt_ff - 1'b1;
               if (div_cnt_ff == DCNT_W'(1)) begin
                  if (div_kind_ff == DIV_FREQ) begin
                     work_in.frequency_store = div_quo_next;
                  end else begin
                     work_in.duty_store = div_quo_next[DUTY_W-1:0];
                  end
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         active_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff <= '0;
         trig_ff <= '0;
         band_ff <= '0;
         enable_ff <= '0;
         div_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         active_ff <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         div_cnt_ff <= div_cnt_in;
         if (mem_wr) begin
            valid_ff[ch_addr] <= 1'b1;
         end
         if (csr_wr) begin
            case (csr_paddr[3:2])
               REG_TRIGGER: trig_ff <= signed'(csr_pwdata[15:0]);
               REG_BAND:    band_ff <= csr_pwdata[13:0];
               REG_ENABLE: begin
                  enable_ff <= csr_pwdata[3:0];
                  for (int c = 0; c < MEM_DEPTH; c++) begin
                     if (!csr_pwdata[c]) begin
                        valid_ff[c] <= 1'b0;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      edge_ff <= edge_in;
      work_ff <= work_in;
      wid_ff <= wid_in;
      prod_ff <= prod_in;
      div_rem_ff <= div_rem_in;
      div_num_ff <= div_num_in;
      div_den_ff <= div_den_in;
      div_quo_ff <= div_quo_in;
      div_kind_ff <= div_kind_in;
      if (req_accept) begin
         ch_ff <= req_channel_index;
         sample_ff <= signed'(req_sample_value);
         time_ff <= req_time_us;
      end
      if (rsp_load) begin
         rsp_ch_ff <= ch_ff;
         rsp_active_ff <= active_ff;
         rsp_edge_ff <= active_ff ? edge_ff : EDGE_NONE;
         rsp_state_ff <= work_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff <= chan_mem[req_addr];
         rd_valid_ff <= valid_ff[req_addr];
      end
      if (mem_wr) begin
         chan_mem[ch_addr] <= work_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_channel = rsp_ch_ff;
   assign rsp_channel_active = rsp_active_ff;
   assign rsp_edge_kind = rsp_edge_ff;
   assign rsp_period_us = rsp_state_ff.period_store;
   assign rsp_frequency_mhz = rsp_state_ff.frequency_store;
   assign rsp_pulse_width_us = rsp_state_ff.pulse_store;
   assign rsp_duty_centipercent = rsp_state_ff.duty_store;
   assign rsp_edge_total = rsp_state_ff.edge_counter;

endmodule
